FILE: hdl/periodic_laplacian_time_kernel_unit_defines.svh
// assertion macros for the periodic laplacian time kernel unit
`ifndef PERIODIC_LAPLACIAN_TIME_KERNEL_UNIT_DEFINES_SVH
`define PERIODIC_LAPLACIAN_TIME_KERNEL_UNIT_DEFINES_SVH

// implication checked on every edge outside reset
`define PLTK_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define PLTK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/pltk_pkg.sv
// ---------------------------------------------------------------------------
// pltk_pkg
// shared types and constants of the laplacian time kernel unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pltk_pkg;

  localparam int unsigned ACC_W  = 40;
  localparam int unsigned MAG_W  = 38;

  // neighbor read order for a compute item
  typedef enum logic [2:0] {
    RD_CENTER = 3'd0,
    RD_XP     = 3'd1,
    RD_XM     = 3'd2,
    RD_YP     = 3'd3,
    RD_YM     = 3'd4,
    RD_ZP     = 3'd5,
    RD_ZM     = 3'd6
  } rd_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    store;     // write loaded beat into memories
    logic    capture;   // latch input beat fields
    logic    rd_en;     // issue a memory read
    rd_sel_t rd_sel;
    logic    acc_clr;   // first read data arrives
    logic    acc_en;    // accumulate neighbor read data
    logic    mult;      // start multiply stage
    logic    combine;   // join partial products
    logic    finish;    // round, saturate, load output register
  } dp_cmd_t;

endpackage
`default_nettype wire

FILE: hdl/pltk_ctrl.sv
// ---------------------------------------------------------------------------
// pltk_ctrl
// sequencer for load and compute beats
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_laplacian_time_kernel_unit_defines.svh"
module pltk_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_fire,
  input  wire logic             in_op,
  input  wire logic             out_busy,
  output logic                  idle,
  output pltk_pkg::dp_cmd_t     cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_FIN  = 5'b01000,
    S_WAIT = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [2:0] rd_cnt, rd_cnt_next;
  logic       rd_pend;
  logic [2:0] rd_last;

  assign idle = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    rd_cnt_next  = rd_cnt;
    cmd          = '0;
    cmd.rd_sel   = pltk_pkg::rd_sel_t'(rd_cnt);
    cmd.acc_clr  = rd_pend && (rd_last == pltk_pkg::RD_CENTER);
    cmd.acc_en   = rd_pend && (rd_last != pltk_pkg::RD_CENTER);
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.capture = 1'b1;
          cmd.store   = !in_op;
          if (in_op) begin
            state_next  = S_READ;
            rd_cnt_next = 3'd0;
          end
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        if (rd_cnt == 3'(pltk_pkg::RD_ZM)) begin
          state_next = S_MUL;
        end else begin
          rd_cnt_next = rd_cnt + 3'd1;
        end
      end
      S_MUL: begin
        if (!rd_pend) begin
          cmd.mult   = 1'b1;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.combine = 1'b1;
        state_next  = S_WAIT;
      end
      S_WAIT: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_cnt  <= 3'd0;
      rd_pend <= 1'b0;
      rd_last <= 3'd0;
    end else begin
      state   <= state_next;
      rd_cnt  <= rd_cnt_next;
      rd_pend <= cmd.rd_en;
      rd_last <= rd_cnt;
    end
  end

  `PLTK_ASSERT_IMP(a_onehot, 1'b1, $onehot(state))
  `PLTK_ASSERT_IMP(a_rd_only_read, cmd.rd_en, state == S_READ)
  `PLTK_ASSERT_NEXT(a_cap_idle, cmd.capture && in_op, !idle)
  `PLTK_ASSERT_IMP(a_fin_free, cmd.finish, !out_busy)

endmodule
`default_nettype wire

FILE: hdl/pltk_datapath.sv
// ---------------------------------------------------------------------------
// pltk_datapath
// site memories, laplacian accumulator, scaling and saturation
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pltk_datapath #(
  parameter int unsigned X_SIZE   = 16,
  parameter int unsigned Y_SIZE   = 16,
  parameter int unsigned Z_SIZE   = 16,
  parameter int unsigned CHANNELS = 4
) (
  input  wire logic              clk,
  input  wire pltk_pkg::dp_cmd_t cmd,
  input  wire logic [1:0]        channel,
  input  wire logic [3:0]        pos_x,
  input  wire logic [3:0]        pos_y,
  input  wire logic [3:0]        pos_z,
  input  wire logic [31:0]       early_re,
  input  wire logic [31:0]       early_im,
  input  wire logic [31:0]       mid_re,
  input  wire logic [31:0]       mid_im,
  input  wire logic [31:0]       late_re,
  input  wire logic [31:0]       late_im,
  input  wire logic [31:0]       inv_two_mass,
  output logic [31:0]            kernel_re,
  output logic [31:0]            kernel_im
);

  localparam int unsigned XW = (X_SIZE > 1) ? $clog2(X_SIZE) : 1;
  localparam int unsigned YW = (Y_SIZE > 1) ? $clog2(Y_SIZE) : 1;
  localparam int unsigned ZW = (Z_SIZE > 1) ? $clog2(Z_SIZE) : 1;
  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned DEPTH = CHANNELS * Z_SIZE * Y_SIZE * X_SIZE;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned ACC_W = pltk_pkg::ACC_W;

  // coordinates reduced modulo size; input values below 16 need at most
  // one subtract when size is at least 8, else a small loop
  function automatic logic [6:0] red(input logic [3:0] v, input int unsigned n);
    logic [6:0] r;
    r = {3'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (r >= 7'(n)) r = r - 7'(n);
    end
    return r;
  endfunction

  logic [CW-1:0] ch_q;
  logic [XW-1:0] x_q;
  logic [YW-1:0] y_q;
  logic [ZW-1:0] z_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch_q <= CW'(red({2'd0, channel}, CHANNELS));
      x_q  <= XW'(red(pos_x, X_SIZE));
      y_q  <= YW'(red(pos_y, Y_SIZE));
      z_q  <= ZW'(red(pos_z, Z_SIZE));
    end
  end

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] c,
      input logic [ZW-1:0] z, input logic [YW-1:0] y, input logic [XW-1:0] x);
    logic [31:0] a;
    a = ((32'(c) * Z_SIZE + 32'(z)) * Y_SIZE + 32'(y)) * X_SIZE + 32'(x);
    return AW'(a);
  endfunction

  logic [XW-1:0] xp, xm;
  logic [YW-1:0] yp, ym;
  logic [ZW-1:0] zp, zm;
  assign xp = (x_q == XW'(X_SIZE - 1)) ? '0 : x_q + XW'(1);
  assign xm = (x_q == '0) ? XW'(X_SIZE - 1) : x_q - XW'(1);
  assign yp = (y_q == YW'(Y_SIZE - 1)) ? '0 : y_q + YW'(1);
  assign ym = (y_q == '0) ? YW'(Y_SIZE - 1) : y_q - YW'(1);
  assign zp = (z_q == ZW'(Z_SIZE - 1)) ? '0 : z_q + ZW'(1);
  assign zm = (z_q == '0) ? ZW'(Z_SIZE - 1) : z_q - ZW'(1);

  logic [AW-1:0] rd_addr, wr_addr;
  always_comb begin
    unique case (cmd.rd_sel)
      pltk_pkg::RD_XP: rd_addr = addr_of(ch_q, z_q, y_q, xp);
      pltk_pkg::RD_XM: rd_addr = addr_of(ch_q, z_q, y_q, xm);
      pltk_pkg::RD_YP: rd_addr = addr_of(ch_q, z_q, yp, x_q);
      pltk_pkg::RD_YM: rd_addr = addr_of(ch_q, z_q, ym, x_q);
      pltk_pkg::RD_ZP: rd_addr = addr_of(ch_q, zp, y_q, x_q);
      pltk_pkg::RD_ZM: rd_addr = addr_of(ch_q, zm, y_q, x_q);
      default:         rd_addr = addr_of(ch_q, z_q, y_q, x_q);
    endcase
  end
  assign wr_addr = addr_of(CW'(red({2'd0, channel}, CHANNELS)), ZW'(red(pos_z, Z_SIZE)),
                           YW'(red(pos_y, Y_SIZE)), XW'(red(pos_x, X_SIZE)));

  function automatic logic [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sd2147483647) return 32'h7fffffff;
    if (v < -33'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  logic [63:0] mid_mem [DEPTH];
  logic [63:0] sum_mem [DEPTH];
  logic [63:0] dif_mem [DEPTH];
  logic [63:0] mid_rd, sum_rd, dif_rd;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mid_mem[wr_addr] <= {mid_im, mid_re};
      sum_mem[wr_addr] <= {sat33(33'(signed'(early_im)) + 33'(signed'(late_im))),
                           sat33(33'(signed'(early_re)) + 33'(signed'(late_re)))};
      dif_mem[wr_addr] <= {sat33(33'(signed'(early_im)) - 33'(signed'(late_im))),
                           sat33(33'(signed'(early_re)) - 33'(signed'(late_re)))};
    end
    if (cmd.rd_en) begin
      mid_rd <= mid_mem[rd_addr];
      sum_rd <= sum_mem[rd_addr];
      dif_rd <= dif_mem[rd_addr];
    end
  end

  // a = 2*(sum6 - 6*mid) + outer_sum - 2*mid = 2*sum6 - 14*mid + outer_sum
  logic signed [ACC_W-1:0] acc_re, acc_im;
  logic signed [31:0]      d_re, d_im;
  logic signed [ACC_W-1:0] m_re, m_im, s_re, s_im;
  assign m_re = ACC_W'(signed'(mid_rd[31:0]));
  assign m_im = ACC_W'(signed'(mid_rd[63:32]));
  assign s_re = ACC_W'(signed'(sum_rd[31:0]));
  assign s_im = ACC_W'(signed'(sum_rd[63:32]));

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_re <= s_re - (m_re <<< 4) + (m_re <<< 1);
      acc_im <= s_im - (m_im <<< 4) + (m_im <<< 1);
      d_re   <= signed'(dif_rd[31:0]);
      d_im   <= signed'(dif_rd[63:32]);
    end else if (cmd.acc_en) begin
      acc_re <= acc_re + (m_re <<< 1);
      acc_im <= acc_im + (m_im <<< 1);
    end
  end

  // multiply stage: magnitude times k as two 16-bit partial products
  localparam int unsigned MW = pltk_pkg::MAG_W;
  logic          neg_re, neg_im;
  logic [MW-1:0] mag_re, mag_im;
  logic [MW+15:0] hi_re, lo_re, hi_im, lo_im;

  assign mag_re = MW'(acc_re < 0 ? -acc_re : acc_re);
  assign mag_im = MW'(acc_im < 0 ? -acc_im : acc_im);

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      neg_re <= acc_re < 0;
      neg_im <= acc_im < 0;
      hi_re  <= mag_re * inv_two_mass[31:16];
      lo_re  <= mag_re * inv_two_mass[15:0];
      hi_im  <= mag_im * inv_two_mass[31:16];
      lo_im  <= mag_im * inv_two_mass[15:0];
    end
  end

  // join stage: partial products combined, early saturation flagged
  logic           ovf_re, ovf_im;
  logic [MW+31:0] p_re, p_im;

  always_ff @(posedge clk) begin
    if (cmd.combine) begin
      ovf_re <= hi_re >= (MW+16)'(64'd1 << 42);
      ovf_im <= hi_im >= (MW+16)'(64'd1 << 42);
      p_re   <= ((MW+32)'(hi_re) << 16) + (MW+32)'(lo_re);
      p_im   <= ((MW+32)'(hi_im) << 16) + (MW+32)'(lo_im);
    end
  end

  function automatic logic [31:0] finish_part(input logic neg, input logic ovf,
      input logic [MW+31:0] p, input logic signed [31:0] d);
    logic signed [72:0]   n;
    logic signed [72:0]   q;
    if (ovf || p >= (MW+32)'(64'd1 << 58)) return neg ? 32'h80000000 : 32'h7fffffff;
    n = neg ? -73'(signed'({1'b0, p})) : 73'(signed'({1'b0, p}));
    n = n + (73'(d) <<< 24) + (73'sd1 <<< 24);
    q = n >>> 25;
    if (q > 73'sd2147483647) return 32'h7fffffff;
    if (q < -73'sd2147483648) return 32'h80000000;
    return q[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      kernel_re <= finish_part(neg_re, ovf_re, p_re, d_re);
      kernel_im <= finish_part(neg_im, ovf_im, p_im, d_im);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/periodic_laplacian_time_kernel_unit.sv
// ---------------------------------------------------------------------------
// periodic_laplacian_time_kernel_unit
// 3-d periodic laplacian time kernel over stored site values
// ---------------------------------------------------------------------------
// load beat: no result, the next beat can follow at once.
// compute beat: seven reads of the site memories, the registered read data,
// the multiply stage, the join stage and the rounding stage lead to
// m_axis_tvalid; the next beat is taken once the output register is loaded,
// later while an earlier result waits. rst (synchronous) clears control and
// sets inv_two_mass to 0.5; memories hold whatever was there until loaded.
`timescale 1ns / 1ps
`default_nettype none
module periodic_laplacian_time_kernel_unit #(
  parameter int unsigned X_SIZE   = 16,
  parameter int unsigned Y_SIZE   = 16,
  parameter int unsigned Z_SIZE   = 16,
  parameter int unsigned CHANNELS = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // channel[1:0] pos_x[5:2] pos_y[9:6] pos_z[13:10] early_re[45:14]
  // early_im[77:46] mid_re[109:78] mid_im[141:110] late_re[173:142]
  // late_im[205:174], zero pad to 208
  input  wire logic [207:0] s_axis_tdata,
  // op
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // kernel_re[31:0] kernel_im[63:32]
  output logic [63:0]       m_axis_tdata,
  input  wire logic         cfg_we,
  input  wire logic [31:0]  cfg_wdata
);

  logic              in_fire, idle;
  pltk_pkg::dp_cmd_t cmd;
  logic [31:0]       inv_two_mass;
  logic [31:0]       k_re, k_im;

  assign s_axis_tready = idle;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_two_mass <= 32'h0080_0000;
    end else if (cfg_we) begin
      inv_two_mass <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end
  assign m_axis_tdata = {k_im, k_re};

  pltk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_op    (s_axis_tuser),
    .out_busy (m_axis_tvalid && !m_axis_tready),
    .idle     (idle),
    .cmd      (cmd)
  );

  pltk_datapath #(
    .X_SIZE   (X_SIZE),
    .Y_SIZE   (Y_SIZE),
    .Z_SIZE   (Z_SIZE),
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .channel      (s_axis_tdata[1:0]),
    .pos_x        (s_axis_tdata[5:2]),
    .pos_y        (s_axis_tdata[9:6]),
    .pos_z        (s_axis_tdata[13:10]),
    .early_re     (s_axis_tdata[45:14]),
    .early_im     (s_axis_tdata[77:46]),
    .mid_re       (s_axis_tdata[109:78]),
    .mid_im       (s_axis_tdata[141:110]),
    .late_re      (s_axis_tdata[173:142]),
    .late_im      (s_axis_tdata[205:174]),
    .inv_two_mass (inv_two_mass),
    .kernel_re    (k_re),
    .kernel_im    (k_im)
  );

endmodule
`default_nettype wire
